/* src/chorus_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chorus package
// Shared constants, sine table and fixed-point helpers for the chorus block.
// ----------------------------------------------------------------------------
package chorus_pkg;

  localparam int BUFFER_DEPTH_DEF     = 4096;
  localparam int SAMPLE_BITS_DEF      = 24;
  localparam int SINE_TABLE_DEPTH_DEF = 256;

  localparam int PHASE_W  = 16;
  localparam int DEPTH_W  = 18;
  localparam int CENTER_W = 20;
  localparam int SINE_W   = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_DELAY = 2'd2;

  localparam logic [PHASE_W-1:0]  PHASE_STEP_RST   = 16'd40;
  localparam logic [DEPTH_W-1:0]  DEPTH_RST        = 18'd65536;
  localparam logic [CENTER_W-1:0] CENTER_DELAY_RST = 20'd262144;

  localparam int GAIN_Q16 = 46341;

  // Restoring shift-and-subtract quotient, used only on constant table inputs.
  function automatic longint unsigned shift_sub_div(input longint unsigned num,
                                                    input longint unsigned den);
    longint unsigned quo, rem;
    quo = 0;
    rem = 0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      quo = {quo[62:0], 1'b0};
      if (rem >= den) begin
        rem = rem - den;
        quo = quo | 64'd1;
      end
    end
    return quo;
  endfunction

  // Quarter-wave sine of q (0..16384), Q1.15, evaluated only for constant table entries.
  function automatic int quarter_sine(input longint unsigned q);
    longint unsigned x, x2, term, plus, minus, s, r;
    x = (q * 64'd1686629713) >> 14;
    x2 = (x * x) >> 30;
    term = x;
    plus = x;
    minus = 0;
    for (int k = 1; k <= 5; k++) begin
      term = shift_sub_div((term * x2) >> 30, longint'((2 * k) * (2 * k + 1)));
      if ((k & 1) == 1) minus += term;
      else plus += term;
    end
    s = (plus > minus) ? plus - minus : 0;
    r = (s + 64'd16384) >> 15;
    if (r > 64'd32767) r = 64'd32767;
    return int'(r);
  endfunction

  function automatic logic signed [SINE_W-1:0] sine_entry(input int i, input int n);
    int p, quad, rr, q, s;
    p = int'((longint'(i) << 16) >> $clog2(n));
    quad = (p >> 14) & 3;
    rr = p & 16383;
    q = ((quad & 1) == 1) ? 16384 - rr : rr;
    s = quarter_sine(longint'(q));
    if (quad >= 2) s = -s;
    return SINE_W'(s);
  endfunction

  typedef struct packed {
    logic start;
    logic busy;
  } ctl_t;

endpackage

/* src/chorus_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chorus delay store
// Single-port synchronous sample memory with registered read data.
// ----------------------------------------------------------------------------
module chorus_store import chorus_pkg::*; #(
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF,
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
  localparam int AW = $clog2(BUFFER_DEPTH)
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [AW-1:0]          addr,
  input  logic [SAMPLE_BITS-1:0] wdata,
  output logic [SAMPLE_BITS-1:0] rdata
);

  logic [SAMPLE_BITS-1:0] mem [BUFFER_DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end

endmodule

/* src/chorus_modulated_delay.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chorus modulated delay
// LFO-modulated delay line with a feedback tap at the centre delay.
// ----------------------------------------------------------------------------
// One sample at a time: a sample is accepted only while the block is idle.
// Each sample takes four reads and one write that share the single port of
// the delay store; a finished sample waits in its last stage until the
// previous result is taken.
// Reset: after rst_n a clearing pass writes zero to every store word, during
// which no sample is accepted (config is).
module chorus_modulated_delay import chorus_pkg::*; #(
  parameter int BUFFER_DEPTH     = BUFFER_DEPTH_DEF,
  parameter int SAMPLE_BITS      = SAMPLE_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_sample_out,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [31:0]                   cfg_data
);

  localparam int AW  = $clog2(BUFFER_DEPTH);
  localparam int SIW = $clog2(SINE_TABLE_DEPTH);
  localparam int PW  = AW + 8;
  localparam int DW  = PW + 2;
  localparam int SB  = SAMPLE_BITS;
  localparam logic signed [DW-1:0] DMIN = DW'(256);
  localparam logic signed [DW-1:0] DMAX = DW'((BUFFER_DEPTH - 2) * 256);
  localparam logic signed [SB+1:0] SMAX = (SB+2)'((64'sd1 <<< (SB - 1)) - 1);
  localparam logic signed [SB+1:0] SMIN = -SMAX - 1;

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_RA1   = 4'd2;
  localparam logic [3:0] ST_RB1   = 4'd3;
  localparam logic [3:0] ST_WA1   = 4'd4;
  localparam logic [3:0] ST_INT1  = 4'd5;
  localparam logic [3:0] ST_G1    = 4'd6;
  localparam logic [3:0] ST_WR    = 4'd7;
  localparam logic [3:0] ST_RA2   = 4'd8;
  localparam logic [3:0] ST_RB2   = 4'd9;
  localparam logic [3:0] ST_WA2   = 4'd10;
  localparam logic [3:0] ST_INT2  = 4'd11;
  localparam logic [3:0] ST_G2    = 4'd12;
  localparam logic [3:0] ST_OUT   = 4'd13;

  logic signed [SINE_W-1:0] sine_rom [SINE_TABLE_DEPTH];
  always_comb begin
    for (int i = 0; i < SINE_TABLE_DEPTH; i++) sine_rom[i] = sine_entry(i, SINE_TABLE_DEPTH);
  end

  logic [3:0]              state_r, state_nxt;
  logic [AW:0]             clr_cnt_r;
  logic [AW-1:0]           widx_r;
  logic [PHASE_W-1:0]      phase_r, phase_step_r;
  logic [DEPTH_W-1:0]      depth_r;
  logic [CENTER_W-1:0]     center_r;
  logic signed [SB-1:0]    x_r, a_r, w_r, y_r;
  logic [PW-1:0]           pos_r;
  logic signed [DW-1:0]    dmod_r;
  logic signed [SB+9:0]    acc_r;
  logic signed [SB+17:0]   prod_r;
  logic signed [SB-1:0]    fb_r;
  logic                    out_valid_r;
  logic                    out_free;

  logic                    mem_we;
  logic [AW-1:0]           mem_addr;
  logic [SB-1:0]           mem_wdata, mem_rdata;

  chorus_store #(.BUFFER_DEPTH(BUFFER_DEPTH), .SAMPLE_BITS(SB)) u_store (
    .clk(clk), .we(mem_we), .addr(mem_addr), .wdata(mem_wdata), .rdata(mem_rdata)
  );

  ctl_t ctl;
  assign ctl.start = in_valid && in_ready;
  assign ctl.busy  = (state_r != ST_IDLE);

  // The result register frees up in the cycle its transfer happens.
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_sample_out = y_r;

  // Read position for a clamped delay.
  function automatic logic [PW-1:0] pos_of(input logic signed [DW-1:0] d,
                                          input logic [AW-1:0] wi);
    logic signed [DW-1:0] c;
    c = (d < DMIN) ? DMIN : ((d > DMAX) ? DMAX : d);
    return PW'({wi, 8'd0}) - PW'(c);
  endfunction

  logic signed [SINE_W-1:0] sine_val;
  logic signed [DEPTH_W+SINE_W:0] dprod;
  assign sine_val = sine_rom[phase_r[PHASE_W-1 -: SIW]];
  assign dprod = (DEPTH_W+SINE_W+1)'($signed({1'b0, depth_r}))
               * (DEPTH_W+SINE_W+1)'(sine_val);

  logic [AW-1:0] addr_a;
  logic [8:0]    f9;
  assign addr_a = pos_r[PW-1:8];
  assign f9 = {1'b0, pos_r[7:0]};

  logic signed [SB+1:0] sum_w, sum_y;
  logic signed [SB-1:0] gprod_rnd;
  logic signed [SB-1:0] w_sat;
  assign gprod_rnd = SB'((prod_r + (SB+18)'(32768)) >>> 16);
  assign sum_w = (SB+2)'(x_r) - (SB+2)'(gprod_rnd);
  assign sum_y = (SB+2)'(fb_r) + (SB+2)'(gprod_rnd);
  assign w_sat = (sum_w > SMAX) ? SB'(SMAX) : ((sum_w < SMIN) ? SB'(SMIN) : SB'(sum_w));

  always_comb begin
    state_nxt = state_r;
    mem_we = 1'b0;
    mem_addr = addr_a;
    mem_wdata = w_r;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_addr = clr_cnt_r[AW-1:0];
        mem_wdata = '0;
        if (clr_cnt_r == (AW+1)'(BUFFER_DEPTH - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: if (ctl.start) state_nxt = ST_RA1;
      ST_RA1:  state_nxt = ST_RB1;
      ST_RB1:  begin mem_addr = addr_a + AW'(1); state_nxt = ST_WA1; end
      ST_WA1:  begin mem_addr = addr_a + AW'(1); state_nxt = ST_INT1; end
      ST_INT1: state_nxt = ST_G1;
      ST_G1:   state_nxt = ST_WR;
      ST_WR:   begin
        mem_we = 1'b1;
        mem_addr = widx_r;
        mem_wdata = w_sat;
        state_nxt = ST_RA2;
      end
      ST_RA2:  state_nxt = ST_RB2;
      ST_RB2:  begin mem_addr = addr_a + AW'(1); state_nxt = ST_WA2; end
      ST_WA2:  begin mem_addr = addr_a + AW'(1); state_nxt = ST_INT2; end
      ST_INT2: state_nxt = ST_G2;
      ST_G2:   state_nxt = ST_OUT;
      ST_OUT:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_cnt_r <= '0;
      widx_r <= '0;
      phase_r <= '0;
      phase_step_r <= PHASE_STEP_RST;
      depth_r <= DEPTH_RST;
      center_r <= CENTER_DELAY_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_cnt_r <= clr_cnt_r + (AW+1)'(1);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PHASE_STEP:   phase_step_r <= cfg_data[PHASE_W-1:0];
          REG_DEPTH:        depth_r <= cfg_data[DEPTH_W-1:0];
          REG_CENTER_DELAY: center_r <= cfg_data[CENTER_W-1:0];
          default: ;
        endcase
      end
      if (state_r == ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
        widx_r <= widx_r + AW'(1);
        phase_r <= phase_r + phase_step_r;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        x_r <= in_sample_in;
        pos_r <= pos_of(DW'(center_r), widx_r);
        dmod_r <= DW'(center_r) + DW'((dprod + (DEPTH_W+SINE_W+1)'(16384)) >>> 15);
      end
      ST_RB1, ST_RB2: a_r <= mem_rdata;
      ST_INT1, ST_INT2: acc_r <= (SB+10)'(a_r) * (SB+10)'($signed({1'b0, 9'd256 - f9}))
                               + (SB+10)'($signed(mem_rdata)) * (SB+10)'($signed(f9))
                               + (SB+10)'(128);
      ST_G1: begin
        fb_r <= SB'(acc_r >>> 8);
        prod_r <= (SB+18)'(SB'(acc_r >>> 8)) * (SB+18)'(GAIN_Q16);
      end
      ST_WR: begin
        w_r <= w_sat;
        pos_r <= pos_of(dmod_r, widx_r);
      end
      ST_G2: begin
        fb_r <= SB'(acc_r >>> 8);
        prod_r <= (SB+18)'(w_r) * (SB+18)'(GAIN_Q16);
      end
      ST_OUT: if (out_free) begin
        y_r <= (sum_y > SMAX) ? SB'(SMAX) : ((sum_y < SMIN) ? SB'(SMIN) : SB'(sum_y));
      end
      default: ;
    endcase
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |=> ctl.busy) else $error("transfer accepted but block not busy");
  a_out_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT) |=> out_valid_r) else $error("result missing after compute");
  a_no_ready_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !in_ready) else $error("input ready during clear");
  a_widx_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(state_r == ST_OUT && out_free) && $past(rst_n) |-> widx_r == $past(widx_r) + AW'(1))
    else $error("write index did not advance");

endmodule
